@@ src/sfc_pkg.sv @@
// sfc_pkg: widths, payload struct and codes shared by the sphere/frustum cull block.
// No dependencies; imported by every module under src.
package sfc_pkg;

  localparam int PLANE_COUNT = 6;   // planes tested, one cell each
  localparam int COORD_WIDTH = 16;  // width of every input field
  localparam int FRAC_BITS   = 8;   // fraction bits of the Q format
  localparam int REG_COUNT   = 6;   // plane registers on the write port
  localparam int COEF_W      = 16;  // one plane coefficient
  localparam int CFG_W       = 4 * COEF_W;
  localparam int IDX_W       = 3;

  localparam int MUL_W  = COEF_W + COORD_WIDTH;  // coefficient times position
  localparam int RAD_W  = 2 * COORD_WIDTH;       // extent times scale
  localparam int WIDE_W = (MUL_W > RAD_W) ? MUL_W : RAD_W;
  localparam int DIST_W = WIDE_W + 3;            // exact sum of five terms

  // coefficient slots inside one plane register
  localparam int SLOT_A = 0;
  localparam int SLOT_B = 1;
  localparam int SLOT_C = 2;
  localparam int SLOT_D = 3;

  typedef logic [CFG_W-1:0] plane_t;

  // what travels from cell to cell
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [RAD_W-1:0]       radius;
    logic                          visible;
  } sfc_item_t;

  function automatic logic signed [COEF_W-1:0] coef(input plane_t p, input int slot);
    coef = p[slot*COEF_W +: COEF_W];
  endfunction

endpackage

@@ src/sfc_radius.sv @@
// sfc_radius: head of the chain; forms the three extent*scale products and
// keeps the largest as the bounding radius. Two elastic stages. Uses sfc_pkg.
module sfc_radius (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] pos_x,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] pos_y,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] pos_z,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] scale_x,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] scale_y,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] scale_z,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] dim_x,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] dim_y,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] dim_z,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output sfc_pkg::sfc_item_t                    dn_item
);
  import sfc_pkg::*;

  logic                          va;
  logic                          vb;
  logic                          ready_b;
  logic signed [COORD_WIDTH-1:0] a_px;
  logic signed [COORD_WIDTH-1:0] a_py;
  logic signed [COORD_WIDTH-1:0] a_pz;
  logic signed [RAD_W-1:0]       rx;
  logic signed [RAD_W-1:0]       ry;
  logic signed [RAD_W-1:0]       rz;
  logic signed [RAD_W-1:0]       rad_next;
  sfc_item_t                     b_item;

  assign ready_b  = !vb || dn_ready;
  assign up_ready = !va || ready_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (up_ready) va <= up_valid;
      if (ready_b)  vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_px <= pos_x;
      a_py <= pos_y;
      a_pz <= pos_z;
      rx   <= dim_x * scale_x;
      ry   <= dim_y * scale_y;
      rz   <= dim_z * scale_z;
    end
  end

  always_comb begin
    rad_next = rx;
    if (ry > rad_next) rad_next = ry;
    if (rz > rad_next) rad_next = rz;
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      b_item.pos_x   <= a_px;
      b_item.pos_y   <= a_py;
      b_item.pos_z   <= a_pz;
      b_item.radius  <= rad_next;
      b_item.visible <= 1'b1;
    end
  end

  assign dn_valid = vb;
  assign dn_item  = b_item;

  // every item leaves the head with no plane against it yet
  a_head_inside: assert property (@(posedge clk) disable iff (rst)
    vb |-> b_item.visible)
    else $error("radius stage emitted an item already marked outside");

endmodule

@@ src/sfc_cell.sv @@
// sfc_cell: one plane of the chain. Stage A registers the three coefficient
// products, stage B sums the distance and clears the inside flag when it is above zero. Uses sfc_pkg.
module sfc_cell (
  input  logic               clk,
  input  logic               rst,
  input  sfc_pkg::plane_t    plane,
  input  logic               up_valid,
  output logic               up_ready,
  input  sfc_pkg::sfc_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output sfc_pkg::sfc_item_t dn_item
);
  import sfc_pkg::*;

  logic                     va;
  logic                     vb;
  logic                     ready_b;
  sfc_item_t                a_item;
  sfc_item_t                b_item;
  sfc_item_t                b_item_next;
  logic signed [MUL_W-1:0]  ax;
  logic signed [MUL_W-1:0]  by;
  logic signed [MUL_W-1:0]  cz;
  logic signed [DIST_W-1:0] d_sh;
  logic signed [DIST_W-1:0] dist_sum;

  assign ready_b  = !vb || dn_ready;
  assign up_ready = !va || ready_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (up_ready) va <= up_valid;
      if (ready_b)  vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_item <= up_item;
      ax     <= coef(plane, SLOT_A) * up_item.pos_x;
      by     <= coef(plane, SLOT_B) * up_item.pos_y;
      cz     <= coef(plane, SLOT_C) * up_item.pos_z;
      d_sh   <= DIST_W'(coef(plane, SLOT_D)) <<< FRAC_BITS;
    end
  end

  assign dist_sum = DIST_W'(ax) + DIST_W'(by) + DIST_W'(cz) + d_sh
                  - DIST_W'(a_item.radius);

  always_comb begin
    b_item_next         = a_item;
    // a zero distance still counts as inside
    b_item_next.visible = a_item.visible && (dist_sum <= 0);
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      b_item <= b_item_next;
    end
  end

  assign dn_valid = vb;
  assign dn_item  = b_item;

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    (va && ready_b && !a_item.visible) |=> !b_item.visible)
    else $error("cell revived an item rejected upstream");

  a_hold_b: assert property (@(posedge clk) disable iff (rst)
    (vb && !dn_ready) |=> (vb && $stable(b_item)))
    else $error("cell lost or changed a stalled result");

  a_hold_a: assert property (@(posedge clk) disable iff (rst)
    (va && !ready_b) |=> (va && $stable(a_item)))
    else $error("cell stage A dropped an item under stall");

endmodule

@@ src/sphere_frustum_cull.sv @@
// Sphere/frustum cull: one object record in, one inside flag out. One record
// is taken every cycle while in_stall is low; the depth is set by the chain of
// plane cells, two stages per plane, behind a two-stage radius head. Every
// stage is elastic, so a stall on the result side only backs up as far as there
// are full stages.
module sphere_frustum_cull (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [sfc_pkg::IDX_W-1:0]             wr_index,
  input  logic [sfc_pkg::CFG_W-1:0]             wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] pos_x,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] pos_y,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] pos_z,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] scale_x,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] scale_y,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] scale_z,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] dim_x,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] dim_y,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] dim_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  inside_res
);
  import sfc_pkg::*;

  plane_t    planes [PLANE_COUNT];
  logic      up_ready;
  logic      lnk_valid [PLANE_COUNT+1];
  logic      lnk_ready [PLANE_COUNT+1];
  sfc_item_t lnk_item  [PLANE_COUNT+1];

  // planes past the register list stay zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_COUNT; i++) planes[i] <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (i < REG_COUNT && 32'(wr_index) == i) planes[i] <= wr_data;
      end
    end
  end

  sfc_radius u_radius (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (up_ready),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .scale_x  (scale_x),
    .scale_y  (scale_y),
    .scale_z  (scale_z),
    .dim_x    (dim_x),
    .dim_y    (dim_y),
    .dim_z    (dim_z),
    .dn_valid (lnk_valid[0]),
    .dn_ready (lnk_ready[0]),
    .dn_item  (lnk_item[0])
  );

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    sfc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .plane    (planes[g]),
      .up_valid (lnk_valid[g]),
      .up_ready (lnk_ready[g]),
      .up_item  (lnk_item[g]),
      .dn_valid (lnk_valid[g+1]),
      .dn_ready (lnk_ready[g+1]),
      .dn_item  (lnk_item[g+1])
    );
  end

  assign lnk_ready[PLANE_COUNT] = !out_stall;
  assign in_stall   = !up_ready;
  assign out_valid  = lnk_valid[PLANE_COUNT];
  assign inside_res = lnk_item[PLANE_COUNT].visible;

endmodule
